// File: design/hst_pkg.sv
// Shared types and constants for the Hermite segment tessellator.
`default_nettype none
package hst_pkg;
	localparam int CoordW  = 16;
	localparam int WeightW = 18;
	localparam int IndexW  = 7;
	localparam int ProdW   = CoordW + WeightW;
	localparam int AccW    = ProdW + 3;
	localparam int FracW   = 16;
	localparam int ShW     = AccW - FracW;

	typedef logic signed [CoordW-1:0]  coord_t;
	typedef logic signed [WeightW-1:0] weight_t;
	typedef logic signed [ProdW-1:0]   prod_t;
	typedef logic signed [AccW-1:0]    acc_t;
	typedef logic [IndexW-1:0]         index_t;

	typedef struct packed {
		coord_t p0x;
		coord_t p0y;
		coord_t p1x;
		coord_t p1y;
		coord_t m0x;
		coord_t m0y;
		coord_t m1x;
		coord_t m1y;
	} segment_t;

	typedef struct packed {
		weight_t w00;
		weight_t w10;
		weight_t w01;
		weight_t w11;
	} weights_t;

	typedef struct packed {
		segment_t seg;
		index_t   j;
		logic     last;
	} issue_t;

	typedef struct packed {
		logic   busy;
		index_t j;
	} seq_status_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		index_t j;
		logic   last;
	} point_t;
endpackage
`default_nettype wire

// File: design/hst_if.sv
// Valid/ready channel interfaces for segments in and points out.
`default_nettype none
interface hst_seg_if;
	import hst_pkg::*;
	logic   valid;
	logic   ready;
	coord_t start_x;
	coord_t start_y;
	coord_t end_x;
	coord_t end_y;
	coord_t out_tangent_x;
	coord_t out_tangent_y;
	coord_t in_tangent_x;
	coord_t in_tangent_y;

	modport source (
		output valid, start_x, start_y, end_x, end_y,
		output out_tangent_x, out_tangent_y, in_tangent_x, in_tangent_y,
		input ready
	);
	modport sink (
		input valid, start_x, start_y, end_x, end_y,
		input out_tangent_x, out_tangent_y, in_tangent_x, in_tangent_y,
		output ready
	);
endinterface

interface hst_pt_if;
	import hst_pkg::*;
	logic   valid;
	logic   ready;
	coord_t point_x;
	coord_t point_y;
	index_t sample_index;
	logic   last_sample;

	modport source (
		output valid, point_x, point_y, sample_index, last_sample,
		input ready
	);
	modport sink (
		input valid, point_x, point_y, sample_index, last_sample,
		output ready
	);
endinterface
`default_nettype wire

// File: design/hst_basis_rom.sv
// Constant table of Q1.16 Hermite basis weights, one row per sample.
`default_nettype none
module hst_basis_rom #(
	parameter int SAMPLES = 20,
	parameter int IW      = 5
) (
	input  logic [IW-1:0]    idx,
	output hst_pkg::weights_t w
);
	import hst_pkg::*;

	weight_t w00_tab [SAMPLES+1];
	weight_t w10_tab [SAMPLES+1];
	weight_t w01_tab [SAMPLES+1];
	weight_t w11_tab [SAMPLES+1];

	for (genvar k = 0; k <= SAMPLES; k++) begin : g_row
		localparam longint S   = SAMPLES;
		localparam longint S3  = S * S * S;
		localparam longint J   = k;
		localparam longint N00 = 2 * J * J * J - 3 * J * J * S + S3;
		localparam longint N10 = J * J * J - 2 * J * J * S + J * S * S;
		localparam longint N01 = -2 * J * J * J + 3 * J * J * S;
		localparam longint N11 = J * J * J - J * J * S;
		localparam longint A00 = (N00 < 0) ? -N00 : N00;
		localparam longint A10 = (N10 < 0) ? -N10 : N10;
		localparam longint A01 = (N01 < 0) ? -N01 : N01;
		localparam longint A11 = (N11 < 0) ? -N11 : N11;
		localparam longint Q00 = (A00 * 131072 + S3) / (2 * S3);
		localparam longint Q10 = (A10 * 131072 + S3) / (2 * S3);
		localparam longint Q01 = (A01 * 131072 + S3) / (2 * S3);
		localparam longint Q11 = (A11 * 131072 + S3) / (2 * S3);
		localparam longint W00 = (N00 < 0) ? -Q00 : Q00;
		localparam longint W10 = (N10 < 0) ? -Q10 : Q10;
		localparam longint W01 = (N01 < 0) ? -Q01 : Q01;
		localparam longint W11 = (N11 < 0) ? -Q11 : Q11;

		assign w00_tab[k] = WeightW'(W00);
		assign w10_tab[k] = WeightW'(W10);
		assign w01_tab[k] = WeightW'(W01);
		assign w11_tab[k] = WeightW'(W11);
	end

	assign w.w00 = w00_tab[idx];
	assign w.w10 = w10_tab[idx];
	assign w.w01 = w01_tab[idx];
	assign w.w11 = w11_tab[idx];
endmodule
`default_nettype wire

// File: design/hst_sequencer.sv
// Segment holding register and sample counter that issues one sample per cycle while advance is high.
`default_nettype none
module hst_sequencer #(
	parameter int SAMPLES = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	hst_seg_if.sink               segment,
	input  logic                  advance,
	output hst_pkg::issue_t       issue,
	output logic                  issue_valid,
	output hst_pkg::seq_status_t  status
);
	import hst_pkg::*;

	localparam int IW = $clog2(SAMPLES + 1);

	logic          busy_q;
	logic [IW-1:0] j_q;
	segment_t      seg_q;
	logic          at_end;
	logic          take;

	assign at_end        = (j_q == IW'(SAMPLES));
	assign segment.ready = !busy_q || (advance && at_end);
	assign take          = segment.valid && segment.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			j_q    <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			j_q    <= '0;
		end else if (advance && busy_q) begin
			if (at_end) begin
				busy_q <= 1'b0;
			end else begin
				j_q <= j_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			seg_q.p0x <= segment.start_x;
			seg_q.p0y <= segment.start_y;
			seg_q.p1x <= segment.end_x;
			seg_q.p1y <= segment.end_y;
			seg_q.m0x <= segment.out_tangent_x;
			seg_q.m0y <= segment.out_tangent_y;
			seg_q.m1x <= segment.in_tangent_x;
			seg_q.m1y <= segment.in_tangent_y;
		end
	end

	assign issue.seg   = seg_q;
	assign issue.j     = IndexW'(j_q);
	assign issue.last  = at_end;
	assign issue_valid = busy_q;
	assign status.busy = busy_q;
	assign status.j    = IndexW'(j_q);
endmodule
`default_nettype wire

// File: design/hst_datapath.sv
// Four-stage pipeline: weight fetch, multiply, sum, round and saturate.
`default_nettype none
module hst_datapath #(
	parameter int SAMPLES = 20
) (
	input  logic             clk,
	input  logic             arst_n,
	input  hst_pkg::issue_t  issue,
	input  logic             issue_valid,
	input  logic             out_ready,
	output logic             advance,
	output hst_pkg::point_t  point,
	output logic             point_valid
);
	import hst_pkg::*;

	localparam int IW = $clog2(SAMPLES + 1);
	localparam acc_t Half = acc_t'(1) <<< (FracW - 1);
	localparam logic signed [ShW-1:0] MaxC = ShW'(32767);
	localparam logic signed [ShW-1:0] MinC = -ShW'(32768);

	weights_t w_lut;

	logic     v_s1, v_s2, v_s3, v_s4;
	segment_t seg_s1;
	weights_t w_s1;
	index_t   j_s1, j_s2, j_s3;
	logic     last_s1, last_s2, last_s3;
	prod_t    px00_s2, px10_s2, px01_s2, px11_s2;
	prod_t    py00_s2, py10_s2, py01_s2, py11_s2;
	acc_t     ax_s3, ay_s3;
	point_t   pt_s4;

	acc_t                    rx, ry;
	logic signed [ShW-1:0]   sx, sy;
	coord_t                  cx, cy;

	hst_basis_rom #(.SAMPLES(SAMPLES), .IW(IW)) u_rom (
		.idx (issue.j[IW-1:0]),
		.w   (w_lut)
	);

	assign advance = !v_s4 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (advance) begin
			v_s1 <= issue_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		rx = ax_s3 + Half;
		ry = ay_s3 + Half;
		sx = ShW'(rx >>> FracW);
		sy = ShW'(ry >>> FracW);
		if (sx > MaxC) begin
			cx = coord_t'(MaxC);
		end else if (sx < MinC) begin
			cx = coord_t'(MinC);
		end else begin
			cx = coord_t'(sx);
		end
		if (sy > MaxC) begin
			cy = coord_t'(MaxC);
		end else if (sy < MinC) begin
			cy = coord_t'(MinC);
		end else begin
			cy = coord_t'(sy);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			seg_s1  <= issue.seg;
			w_s1    <= w_lut;
			j_s1    <= issue.j;
			last_s1 <= issue.last;

			px00_s2 <= w_s1.w00 * seg_s1.p0x;
			px10_s2 <= w_s1.w10 * seg_s1.m0x;
			px01_s2 <= w_s1.w01 * seg_s1.p1x;
			px11_s2 <= w_s1.w11 * seg_s1.m1x;
			py00_s2 <= w_s1.w00 * seg_s1.p0y;
			py10_s2 <= w_s1.w10 * seg_s1.m0y;
			py01_s2 <= w_s1.w01 * seg_s1.p1y;
			py11_s2 <= w_s1.w11 * seg_s1.m1y;
			j_s2    <= j_s1;
			last_s2 <= last_s1;

			ax_s3   <= AccW'(px00_s2) + AccW'(px10_s2) + AccW'(px01_s2) + AccW'(px11_s2);
			ay_s3   <= AccW'(py00_s2) + AccW'(py10_s2) + AccW'(py01_s2) + AccW'(py11_s2);
			j_s3    <= j_s2;
			last_s3 <= last_s2;

			pt_s4.x    <= cx;
			pt_s4.y    <= cy;
			pt_s4.j    <= j_s3;
			pt_s4.last <= last_s3;
		end
	end

	assign point       = pt_s4;
	assign point_valid = v_s4;
endmodule
`default_nettype wire

// File: design/hermite_segment_tessellator.sv
// Top level: cubic Hermite segment tessellator, SAMPLES+1 points per segment.
// A segment is held in the sequencer; its points pass stages s1 to s4 before output.
// Throughput: one point per cycle unless point.ready stalls the pipeline; the
// sample counter issues one basis row per cycle into the pipeline while it advances.
// Reset clears the sequencer and the pipeline valid bits; data registers are not reset.
`default_nettype none
module hermite_segment_tessellator #(
	parameter int SAMPLES = 20
) (
	input  logic      clk,
	input  logic      arst_n,
	hst_seg_if.sink   segment,
	hst_pt_if.source  point
);
	import hst_pkg::*;

	issue_t      issue;
	logic        issue_valid;
	logic        advance;
	seq_status_t status;
	point_t      pt;
	logic        pt_valid;

	hst_sequencer #(.SAMPLES(SAMPLES)) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.segment     (segment),
		.advance     (advance),
		.issue       (issue),
		.issue_valid (issue_valid),
		.status      (status)
	);

	hst_datapath #(.SAMPLES(SAMPLES)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.issue       (issue),
		.issue_valid (issue_valid),
		.out_ready   (point.ready),
		.advance     (advance),
		.point       (pt),
		.point_valid (pt_valid)
	);

	assign point.valid        = pt_valid;
	assign point.point_x      = pt.x;
	assign point.point_y      = pt.y;
	assign point.sample_index = pt.j;
	assign point.last_sample  = pt.last;

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		point.valid |-> (point.last_sample == (point.sample_index == IndexW'(SAMPLES))))
		else $error("last flag does not match sample index");

	a_take_restart: assert property (@(posedge clk) disable iff (!arst_n)
		segment.valid && segment.ready |=> status.busy && status.j == '0)
		else $error("segment transfer did not restart the sample counter");

	a_ready_busy: assert property (@(posedge clk) disable iff (!arst_n)
		segment.ready && status.busy |-> advance && status.j == IndexW'(SAMPLES))
		else $error("segment ready while samples remain");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		status.busy |-> status.j <= IndexW'(SAMPLES))
		else $error("sample counter out of range");
endmodule
`default_nettype wire
